// ----- rtl/core/mdbfd_pkg.sv -----
// ----------------------------------------------------------------------------
// mdbfd_pkg
// Types, codes and constants of the 9-bit multi-drop bus master framer and
// deframer.
// ----------------------------------------------------------------------------
package mdbfd_pkg;

	// Longest message in either direction, in data bytes
	localparam int unsigned MAX_LEN = 36;

	localparam logic [5:0] SEND_CNT_MAX  = 6'(MAX_LEN);
	localparam logic [5:0] SEND_CNT_OVER = 6'(MAX_LEN + 1);
	// Raw receive bytes kept: data plus the three bytes of the end mark
	localparam logic [6:0] RECV_RAW_MAX  = 7'(MAX_LEN + 3);

	localparam logic [7:0] ESC_BYTE  = 8'hFF;
	localparam logic [7:0] MARK_BYTE = 8'h00;

	// Configuration register indexes
	localparam logic CFG_ACK  = 1'b0;
	localparam logic CFG_NACK = 1'b1;

	localparam logic [7:0] ACK_RESET  = 8'h00;
	localparam logic [7:0] NACK_RESET = 8'hFF;

	typedef enum logic [1:0] {
		MODE_SEND = 2'd0,
		MODE_RECV = 2'd1,
		MODE_END  = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TIMEOUT  = 3'd1,
		ST_IO_ERR   = 3'd2,
		ST_CHECKSUM = 3'd3,
		ST_NO_MARK  = 3'd4,
		ST_BAD_LEN  = 3'd5
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic       ninth_bit;
		status_t    status;
		logic [5:0] reply_length;
		logic       last;
	} result_t;

	function automatic result_t mk_char(logic [7:0] c, logic ninth);
		result_t r;
		r              = '0;
		r.kind         = KIND_CHAR;
		r.out_byte     = c;
		r.ninth_bit    = ninth;
		r.status       = ST_OK;
		return r;
	endfunction

	function automatic result_t mk_data(logic [7:0] b);
		result_t r;
		r          = '0;
		r.kind     = KIND_DATA;
		r.out_byte = b;
		r.status   = ST_OK;
		return r;
	endfunction

	function automatic result_t mk_status(status_t st, logic [5:0] len);
		result_t r;
		r              = '0;
		r.kind         = KIND_STATUS;
		r.status       = st;
		r.reply_length = len;
		return r;
	endfunction

endpackage

// ----- rtl/core/mdb_master_framer_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// mdb_master_framer_deframer_unit
// Master side of a 9-bit multi-drop bus: frames outgoing messages with the
// address and checksum, deframes escaped replies and reports a status.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake         | payload
//  s_axis    | in        | s_tvalid/s_tready | tuser mode, tdata byte+address,
//            |           |                   | tlast send_last
//  m_axis    | out       | m_tvalid/m_tready | tuser kind, tdata result fields,
//            |           |                   | tlast final result of an item
//  cfg       | in        | cfg_we            | cfg_addr register, cfg_wdata
//
// An item is registered on accept, then worked out combinationally into up to
// three results that leave the output buffer one per cycle while m_tready is
// high. An item with more than one result holds the input register until its
// last result is taken, set by the single output port. A full input register
// and a result waiting on m_tready stall s_tready. Reset is asynchronous and
// clears all bus state.
// ----------------------------------------------------------------------------
module mdb_master_framer_deframer_unit
	import mdbfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [7:0] data_byte, [15:8] address
	input  logic [1:0]  s_tuser,    // [1:0] mode
	input  logic        s_tlast,    // send_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [7:0] out_byte, [8] ninth_bit,
	                                // [11:9] status, [17:12] reply_length, [23:18] zero
	output logic [1:0]  m_tuser,    // [1:0] kind
	output logic        m_tlast,    // last
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [7:0]  cfg_wdata
);

	// Configuration
	logic [7:0] ack_q, nack_q;

	// Input register
	logic       valid_s1;
	mode_t      mode_s1;
	logic [7:0] byte_s1, addr_s1;
	logic       last_s1;

	// Bus state
	logic [7:0] send_sum_q, recv_sum_q;
	logic [5:0] send_cnt_q, recv_cnt_q;
	logic [7:0] la0_q, la1_q;
	logic [1:0] la_fill_q;
	logic       mark_seen_q, mark_extra_q;
	logic [7:0] mark_x_q;

	logic [7:0] send_sum_d, recv_sum_d;
	logic [5:0] send_cnt_d, recv_cnt_d;
	logic [7:0] la0_d, la1_d;
	logic [1:0] la_fill_d;
	logic       mark_seen_d, mark_extra_d;
	logic [7:0] mark_x_d;

	// Result buffer
	result_t    res_q [3];
	result_t    res_d [3];
	logic [1:0] rem_q, rptr_q;
	logic [1:0] n_d;
	result_t    head;

	logic       advance, buf_free, out_fire;
	logic [7:0] c_send, sum_send;
	logic [6:0] raw_cnt;

	// Handshake
	assign out_fire = m_tvalid && m_tready;
	assign buf_free = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_tready);
	assign advance  = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || buf_free;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_q  <= ACK_RESET;
			nack_q <= NACK_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ACK:  ack_q  <= cfg_wdata;
				CFG_NACK: nack_q <= cfg_wdata;
				default:  ;
			endcase
		end
	end

	// Capture the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= mode_t'(s_tuser);
			byte_s1 <= s_tdata[7:0];
			addr_s1 <= s_tdata[15:8];
			last_s1 <= s_tlast;
		end
	end

	// First byte carries the address; the checksum covers every character sent before it
	assign c_send   = (send_cnt_q == 6'd0) ? (addr_s1 | byte_s1) : byte_s1;
	assign sum_send = send_sum_q + c_send;
	assign raw_cnt  = {1'b0, recv_cnt_q} + {5'd0, la_fill_q};

	// Work out the results and the next state of one item
	always_comb begin
		send_sum_d   = send_sum_q;
		send_cnt_d   = send_cnt_q;
		recv_sum_d   = recv_sum_q;
		recv_cnt_d   = recv_cnt_q;
		la0_d        = la0_q;
		la1_d        = la1_q;
		la_fill_d    = la_fill_q;
		mark_seen_d  = mark_seen_q;
		mark_extra_d = mark_extra_q;
		mark_x_d     = mark_x_q;
		res_d[0]     = '0;
		res_d[1]     = '0;
		res_d[2]     = '0;
		n_d          = 2'd0;

		case (mode_s1)
			MODE_SEND: begin
				if (send_cnt_q > SEND_CNT_MAX) begin
					// Drop the rest of an overlong message
					if (last_s1) begin
						send_sum_d = '0;
						send_cnt_d = '0;
					end
				end else if (send_cnt_q == SEND_CNT_MAX) begin
					res_d[0] = mk_status(ST_BAD_LEN, 6'd0);
					n_d      = 2'd1;
					if (last_s1) begin
						send_sum_d = '0;
						send_cnt_d = '0;
					end else begin
						send_cnt_d = SEND_CNT_OVER;
					end
				end else begin
					// Start of message flushes the receive side
					if (send_cnt_q == 6'd0) begin
						recv_sum_d   = '0;
						recv_cnt_d   = '0;
						la0_d        = '0;
						la1_d        = '0;
						la_fill_d    = '0;
						mark_seen_d  = 1'b0;
						mark_extra_d = 1'b0;
						mark_x_d     = '0;
					end
					res_d[0]   = mk_char(c_send, send_cnt_q == 6'd0);
					n_d        = 2'd1;
					send_sum_d = sum_send;
					send_cnt_d = send_cnt_q + 6'd1;
					if (last_s1) begin
						res_d[1]   = mk_char(sum_send, 1'b0);
						n_d        = 2'd2;
						send_sum_d = '0;
						send_cnt_d = '0;
					end
				end
			end
			MODE_RECV: begin
				if (mark_seen_q) begin
					mark_extra_d = 1'b1;
				end else if (raw_cnt < RECV_RAW_MAX) begin
					if (la_fill_q == 2'd2) begin
						if (la0_q == ESC_BYTE && la1_q == MARK_BYTE) begin
							mark_seen_d  = 1'b1;
							mark_x_d     = byte_s1;
							mark_extra_d = 1'b0;
							la_fill_d    = '0;
						end else begin
							// Oldest lookahead byte is data
							res_d[0]   = mk_data(la0_q);
							n_d        = 2'd1;
							recv_sum_d = recv_sum_q + la0_q;
							recv_cnt_d = recv_cnt_q + 6'd1;
							la0_d      = la1_q;
							la1_d      = byte_s1;
						end
					end else begin
						if (la_fill_q[0]) begin
							la1_d = byte_s1;
						end else begin
							la0_d = byte_s1;
						end
						la_fill_d = la_fill_q + 2'd1;
					end
				end
			end
			MODE_END: begin
				if (mark_seen_q) begin
					if (recv_cnt_q == 6'd0 && !mark_extra_q) begin
						// Lone ACK or NACK reply
						if (mark_x_q == ack_q || mark_x_q == nack_q) begin
							res_d[0] = mk_data(mark_x_q);
							res_d[1] = mk_status(ST_OK, 6'd1);
							n_d      = 2'd2;
						end else begin
							res_d[0] = mk_status(ST_IO_ERR, 6'd0);
							n_d      = 2'd1;
						end
					end else if (mark_x_q == recv_sum_q) begin
						res_d[0] = mk_char(ack_q, 1'b0);
						res_d[1] = mk_status(ST_OK, recv_cnt_q);
						n_d      = 2'd2;
					end else begin
						res_d[0] = mk_char(nack_q, 1'b0);
						res_d[1] = mk_status(ST_CHECKSUM, recv_cnt_q);
						n_d      = 2'd2;
					end
				end else if (recv_cnt_q == 6'd0 && la_fill_q == 2'd0) begin
					res_d[0] = mk_status(ST_TIMEOUT, 6'd0);
					n_d      = 2'd1;
				end else begin
					// Flush the lookahead as data, then report no end mark
					case (la_fill_q)
						2'd0: begin
							res_d[0] = mk_status(ST_NO_MARK, recv_cnt_q);
							n_d      = 2'd1;
						end
						2'd1: begin
							res_d[0] = mk_data(la0_q);
							res_d[1] = mk_status(ST_NO_MARK, recv_cnt_q + 6'd1);
							n_d      = 2'd2;
						end
						default: begin
							res_d[0] = mk_data(la0_q);
							res_d[1] = mk_data(la1_q);
							res_d[2] = mk_status(ST_NO_MARK, recv_cnt_q + 6'd2);
							n_d      = 2'd3;
						end
					endcase
				end
				// End of transaction clears both directions
				send_sum_d   = '0;
				send_cnt_d   = '0;
				recv_sum_d   = '0;
				recv_cnt_d   = '0;
				la0_d        = '0;
				la1_d        = '0;
				la_fill_d    = '0;
				mark_seen_d  = 1'b0;
				mark_extra_d = 1'b0;
				mark_x_d     = '0;
			end
			default: ;
		endcase

		// Mark the final result of the item
		case (n_d)
			2'd1:    res_d[0].last = 1'b1;
			2'd2:    res_d[1].last = 1'b1;
			2'd3:    res_d[2].last = 1'b1;
			default: ;
		endcase
	end

	// Advance the bus state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_sum_q   <= '0;
			send_cnt_q   <= '0;
			recv_sum_q   <= '0;
			recv_cnt_q   <= '0;
			la0_q        <= '0;
			la1_q        <= '0;
			la_fill_q    <= '0;
			mark_seen_q  <= 1'b0;
			mark_extra_q <= 1'b0;
			mark_x_q     <= '0;
		end else if (advance) begin
			send_sum_q   <= send_sum_d;
			send_cnt_q   <= send_cnt_d;
			recv_sum_q   <= recv_sum_d;
			recv_cnt_q   <= recv_cnt_d;
			la0_q        <= la0_d;
			la1_q        <= la1_d;
			la_fill_q    <= la_fill_d;
			mark_seen_q  <= mark_seen_d;
			mark_extra_q <= mark_extra_d;
			mark_x_q     <= mark_x_d;
		end
	end

	// Result buffer: load on advance, drain one result per output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			rptr_q <= '0;
		end else if (advance) begin
			rem_q  <= n_d;
			rptr_q <= '0;
		end else if (out_fire) begin
			rem_q  <= rem_q - 2'd1;
			rptr_q <= rptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q[0] <= res_d[0];
			res_q[1] <= res_d[1];
			res_q[2] <= res_d[2];
		end
	end

	// Select the head result
	always_comb begin
		case (rptr_q)
			2'd1:    head = res_q[1];
			2'd2:    head = res_q[2];
			default: head = res_q[0];
		endcase
	end

	assign m_tvalid = (rem_q != 2'd0);
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;
	assign m_tdata  = {6'd0, head.reply_length, head.status, head.ninth_bit, head.out_byte};

`ifndef SYNTHESIS
	// Buffer never reads past its three entries
	assert property (@(posedge clk) disable iff (!arst_n)
		(({1'b0, rptr_q} + {1'b0, rem_q}) <= 3'd3))
		else $error("result buffer pointer past end");

	// Only the final buffered result of an item carries last
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (rem_q == 2'd1)))
		else $error("last flag out of place");

	// New results load only into an empty or emptying buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (rem_q == 2'd0 || (rem_q == 2'd1 && out_fire)))
		else $error("results overwritten");

	// Send counter stops one past the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		send_cnt_q <= SEND_CNT_OVER)
		else $error("send count out of range");

	// Lookahead holds at most two bytes and is empty after the end mark
	assert property (@(posedge clk) disable iff (!arst_n)
		(la_fill_q != 2'd3) && (!mark_seen_q || la_fill_q == 2'd0))
		else $error("lookahead fill out of range");
`endif

endmodule
